// ===== hdl/float_rgb_to_rgbe_top_defines.svh =====
// Assertion helpers used by the top-level RTL file
`ifndef FLOAT_RGB_TO_RGBE_TOP_DEFINES_SVH
`define FLOAT_RGB_TO_RGBE_TOP_DEFINES_SVH

// Same-cycle implication under reset
`define RGBE_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("rgbe assertion failed");

// Next-cycle implication under reset
`define RGBE_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("rgbe assertion failed");

`endif

// ===== hdl/rgbe_pkg.sv =====
package rgbe_pkg;

  // 255.9999 = 2559999 / 10000
  localparam logic [21:0] ScaleNum  = 22'd2559999;
  // ceil(2^37 / 10000), exact floor for quotients below 2^22
  localparam logic [23:0] RecipDen  = 24'd13743896;
  localparam int unsigned RecipSh   = 37;
  // largest single-precision magnitude not above 1e-32
  localparam logic [30:0] DarkLimit = 31'h0A4FB11E;
  // e + 128 = biased exponent + 2 for a normal maximum
  localparam logic [7:0]  ExpAdj    = 8'd2;
  localparam logic [8:0]  ShiftBase = 9'd24;
  localparam logic [5:0]  ShiftMax  = 6'd63;

  typedef struct packed {
    logic [31:0] red_bits;
    logic [31:0] green_bits;
    logic [31:0] blue_bits;
    logic        line_end;
  } rgbe_in_t;

  typedef struct packed {
    logic [7:0] red_mantissa;
    logic [7:0] green_mantissa;
    logic [7:0] blue_mantissa;
    logic [7:0] shared_exponent;
    logic       invalid;
    logic       line_end_out;
  } rgbe_out_t;

  // float a > b for finite patterns, with -0 equal to +0
  function automatic logic fgt(logic [31:0] a, logic [31:0] b);
    logic za, zb, res;
    za = (a[30:0] == '0);
    zb = (b[30:0] == '0);
    if (za && zb) res = 1'b0;
    else if (!a[31] && b[31]) res = 1'b1;
    else if (a[31] && !b[31]) res = 1'b0;
    else if (!a[31]) res = (a[30:0] > b[30:0]);
    else res = (a[30:0] < b[30:0]);
    return res;
  endfunction

endpackage

// ===== hdl/rgbe_chan.sv =====
module rgbe_chan (
  input  logic        clk_i,
  input  logic [31:0] bits_i,
  input  logic [7:0]  exp_m_i,
  input  logic        zero_i,
  output logic [7:0]  mant_o
);
  import rgbe_pkg::*;

  logic        pos;
  logic [7:0]  eff_exp;
  logic [8:0]  shift;
  logic        kill_d, kill_q, kill2_q;
  logic [23:0] mant;
  logic [45:0] prod_d, prod_q;
  logic [5:0]  sh_q;
  logic [45:0] shifted;
  logic [21:0] quot_in;
  logic [45:0] recip_d, recip_q;
  logic [7:0]  mant_q;

  // classify the channel and form mantissa times the scale numerator
  always_comb begin
    pos     = !bits_i[31] && (bits_i[30:0] != '0) && !zero_i;
    eff_exp = (bits_i[30:23] == '0) ? 8'd1 : bits_i[30:23];
    mant    = {(bits_i[30:23] != '0), bits_i[22:0]};
    shift   = {1'b0, exp_m_i} + ShiftBase - {1'b0, eff_exp};
    kill_d  = !pos || (shift >= {3'b000, ShiftMax});
    prod_d  = mant * ScaleNum;
  end

  // align to the shared exponent, then divide by 10000 via reciprocal
  always_comb begin
    shifted = prod_q >> sh_q;
    quot_in = shifted[21:0];
    recip_d = quot_in * RecipDen;
  end

  // advance the channel pipeline
  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    sh_q    <= shift[5:0];
    kill_q  <= kill_d;
    recip_q <= recip_d;
    kill2_q <= kill_q;
    mant_q  <= kill2_q ? 8'd0 : recip_q[RecipSh +: 8];
  end

  assign mant_o = mant_q;

endmodule

// ===== hdl/float_rgb_to_rgbe_top.sv =====
// RGBE encoder: takes one float RGB pixel per clock and returns three
// mantissa bytes, a shared exponent byte and invalid and line-end flags.
// busy_o is never raised, so a pixel may be started in every cycle; its
// result shows on res_o with done_o high for one cycle. A pixel passes
// through the input register, the scale multiply, the divide-by-10000
// reciprocal multiply and the result register. The receiver cannot stall:
// every result must be taken in the cycle done_o is high.
`include "float_rgb_to_rgbe_top_defines.svh"

module float_rgb_to_rgbe_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  rgbe_pkg::rgbe_in_t in_i,
  output logic              busy_o,
  output logic              done_o,
  output rgbe_pkg::rgbe_out_t res_o
);
  import rgbe_pkg::*;

  rgbe_in_t    in_q;
  logic        va_q, vb_q, vc_q, vo_q;
  logic        inv_b_q, inv_c_q, inv_o_q;
  logic        le_b_q, le_c_q, le_o_q;
  logic [7:0]  ex_b_q, ex_c_q, ex_o_q;
  logic        inv_d, dark, zero_all;
  logic [31:0] max_rg, max_bits;
  logic [7:0]  exp_d;
  logic [7:0]  m_r, m_g, m_b;

  assign busy_o = 1'b0;

  // track which pipeline stages hold an accepted pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      va_q <= start_i && !busy_o;
      vb_q <= va_q;
      vc_q <= vb_q;
      vo_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= in_i;
    end
  end

  // find the largest channel and classify the pixel
  always_comb begin
    inv_d    = (in_q.red_bits[30:23] == 8'hFF) || (in_q.green_bits[30:23] == 8'hFF)
            || (in_q.blue_bits[30:23] == 8'hFF);
    max_rg   = fgt(in_q.red_bits, in_q.green_bits) ? in_q.red_bits : in_q.green_bits;
    max_bits = fgt(in_q.blue_bits, max_rg) ? in_q.blue_bits : max_rg;
    dark     = max_bits[31] || (max_bits[30:0] <= DarkLimit);
    zero_all = inv_d || dark;
    exp_d    = zero_all ? 8'd0 : max_bits[30:23] + ExpAdj;
  end

  rgbe_chan u_red (
    .clk_i  (clk_i),
    .bits_i (in_q.red_bits),
    .exp_m_i(max_bits[30:23]),
    .zero_i (zero_all),
    .mant_o (m_r)
  );

  rgbe_chan u_green (
    .clk_i  (clk_i),
    .bits_i (in_q.green_bits),
    .exp_m_i(max_bits[30:23]),
    .zero_i (zero_all),
    .mant_o (m_g)
  );

  rgbe_chan u_blue (
    .clk_i  (clk_i),
    .bits_i (in_q.blue_bits),
    .exp_m_i(max_bits[30:23]),
    .zero_i (zero_all),
    .mant_o (m_b)
  );

  // carry the per-pixel flags and shared exponent alongside the channel pipelines
  always_ff @(posedge clk_i) begin
    inv_b_q <= inv_d;
    le_b_q  <= in_q.line_end;
    ex_b_q  <= exp_d;
    inv_c_q <= inv_b_q;
    le_c_q  <= le_b_q;
    ex_c_q  <= ex_b_q;
    inv_o_q <= inv_c_q;
    le_o_q  <= le_c_q;
    ex_o_q  <= ex_c_q;
  end

  assign done_o                = vo_q;
  assign res_o.red_mantissa    = m_r;
  assign res_o.green_mantissa  = m_g;
  assign res_o.blue_mantissa   = m_b;
  assign res_o.shared_exponent = ex_o_q;
  assign res_o.invalid         = inv_o_q;
  assign res_o.line_end_out    = le_o_q;

  `RGBE_ASSERT_NXT(a_flow_b, clk_i, rst_ni, va_q, vb_q)
  `RGBE_ASSERT_NXT(a_flow_o, clk_i, rst_ni, vc_q, done_o)
  `RGBE_ASSERT_IMP(a_inv_zero, clk_i, rst_ni, done_o && res_o.invalid,
                   (res_o.shared_exponent == 8'd0) && (res_o.red_mantissa == 8'd0))
  `RGBE_ASSERT_IMP(a_no_busy, clk_i, rst_ni, 1'b1, !busy_o)

endmodule
